FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

    localparam int unsigned TICK_COUNT_WIDTH = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Class of an item as the front part sorts it.
    typedef enum logic [1:0] {
        CL_TICK   = 2'd0,
        CL_WRITE  = 2'd1,
        CL_READ   = 2'd2,
        CL_IGNORE = 2'd3
    } item_class_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_BUSY    = 3'd1,
        ST_DONE_OK = 3'd2,
        ST_NACK    = 3'd3,
        ST_REJECT  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE         = 5'd0,
        PH_PENDING      = 5'd1,
        PH_ST_CLK_LOW   = 5'd2,
        PH_ST_DATA_UP   = 5'd3,
        PH_ST_CLK_UP    = 5'd4,
        PH_ST_SETTLE    = 5'd5,
        PH_ST_RAISE     = 5'd6,
        PH_ST_DATA_DOWN = 5'd7,
        PH_ST_CLK_DOWN  = 5'd8,
        PH_WB_SET       = 5'd9,
        PH_WB_HIGH      = 5'd10,
        PH_WB_LOW       = 5'd11,
        PH_NACK_LOW     = 5'd12,
        PH_RB_RELEASE   = 5'd13,
        PH_RB_HIGH      = 5'd14,
        PH_RB_LOW       = 5'd15,
        PH_SP_LOW       = 5'd16,
        PH_SP_HIGH      = 5'd17,
        PH_SP_END       = 5'd18,
        PH_AB_LOW       = 5'd19,
        PH_AB_HIGH      = 5'd20,
        PH_AB_END       = 5'd21
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       scl_sampled;
        logic       sda_sampled;
    } item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic [2:0] status;
        logic [7:0] read_data;
    } result_t;

    // One classified item waiting between front and engine.
    typedef struct packed {
        item_class_t cls;
        logic [7:0]  device_address;
        logic [7:0]  register_address;
        logic [7:0]  write_data;
        logic        scl_sampled;
        logic        sda_sampled;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

endpackage

FILE: rtl/i2cm_front.sv
module i2cm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  i2cm_pkg::item_t      item,
    output i2cm_pkg::queue_head_t head,
    input  logic                 take
);

    i2cm_pkg::entry_t mem_reg [i2cm_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;
    i2cm_pkg::entry_t classified;

    // Sort the item by its opcode; the engine then only looks at the class.
    always_comb
    begin
        classified.device_address   = item.device_address;
        classified.register_address = item.register_address;
        classified.write_data       = item.write_data;
        classified.scl_sampled      = item.scl_sampled;
        classified.sda_sampled      = item.sda_sampled;
        case (item.opcode)
            i2cm_pkg::OP_TICK:  classified.cls = i2cm_pkg::CL_TICK;
            i2cm_pkg::OP_WRITE: classified.cls = i2cm_pkg::CL_WRITE;
            i2cm_pkg::OP_READ:  classified.cls = i2cm_pkg::CL_READ;
            default:            classified.cls = i2cm_pkg::CL_IGNORE;
        endcase
    end

    assign full    = (count_reg == 2'(i2cm_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = take && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

FILE: rtl/i2cm_engine.sv
module i2cm_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    input  i2cm_pkg::queue_head_t head,
    output logic                  take,
    output logic                  empty,
    input  logic                  pop,
    output i2cm_pkg::result_t     result
);

    localparam int unsigned CW = i2cm_pkg::TICK_COUNT_WIDTH;

    logic [15:0]       phase_ticks_reg;
    i2cm_pkg::phase_t  ph_reg, ph_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [7:0]        shift_reg, shift_next;
    logic [3:0]        bc_reg, bc_next;
    logic [1:0]        byc_reg, byc_next;
    logic              is_read_reg, is_read_next;
    logic [7:0]        dev_reg, dev_next;
    logic [7:0]        regad_reg, regad_next;
    logic [7:0]        data_reg, data_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;

    i2cm_pkg::result_t res_mem_reg [i2cm_pkg::QUEUE_DEPTH];
    logic              res_wr_reg, res_rd_reg;
    logic [1:0]        res_cnt_reg;
    logic              do_pop, room;

    i2cm_pkg::result_t new_res;
    logic [CW-1:0]     load_val;
    logic [CW-1:0]     cnt_dec;
    i2cm_pkg::phase_t  tgt;
    i2cm_pkg::status_t status;
    i2cm_pkg::status_t fin;
    logic              entered;
    logic              busy;
    logic              hold;
    logic              scl_in, sda_in;

    assign cfg_ready = 1'b1;

    // Zero acts as one; a value beyond the counter saturates at its top.
    always_comb
    begin
        if (phase_ticks_reg == 16'd0)
        begin
            load_val = CW'(1);
        end
        else if (CW < 16 && (32'(phase_ticks_reg) > (32'(1) << CW) - 32'd1))
        begin
            load_val = '1;
        end
        else
        begin
            load_val = CW'(phase_ticks_reg);
        end
    end

    function automatic i2cm_pkg::phase_t start_phase(input logic scl, input logic sda);
        i2cm_pkg::phase_t p;
        if (scl)
        begin
            p = sda ? i2cm_pkg::PH_ST_SETTLE : i2cm_pkg::PH_ST_CLK_LOW;
        end
        else
        begin
            p = i2cm_pkg::PH_ST_RAISE;
        end
        return p;
    endfunction

    function automatic logic raises_clock(input i2cm_pkg::phase_t p);
        return (p == i2cm_pkg::PH_ST_CLK_UP) || (p == i2cm_pkg::PH_WB_HIGH) ||
               (p == i2cm_pkg::PH_RB_HIGH) || (p == i2cm_pkg::PH_SP_HIGH) ||
               (p == i2cm_pkg::PH_AB_HIGH);
    endfunction

    assign do_pop = pop && (res_cnt_reg != 2'd0);
    assign room   = (res_cnt_reg != 2'(i2cm_pkg::QUEUE_DEPTH)) || do_pop;
    assign take   = head.valid && room;
    assign scl_in = head.entry.scl_sampled;
    assign sda_in = head.entry.sda_sampled;
    assign busy   = (ph_reg != i2cm_pkg::PH_IDLE);
    assign hold   = raises_clock(ph_reg) && !scl_in;
    assign cnt_dec = (cnt_reg != '0) ? cnt_reg - CW'(1) : '0;

    always_comb
    begin
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        bc_next      = bc_reg;
        byc_next     = byc_reg;
        is_read_next = is_read_reg;
        dev_next     = dev_reg;
        regad_next   = regad_reg;
        data_next    = data_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        tgt          = ph_reg;
        entered      = 1'b0;
        fin          = i2cm_pkg::ST_IDLE;
        status       = busy ? i2cm_pkg::ST_BUSY : i2cm_pkg::ST_IDLE;

        case (head.entry.cls)
            i2cm_pkg::CL_WRITE, i2cm_pkg::CL_READ:
            begin
                if (busy)
                begin
                    status = i2cm_pkg::ST_REJECT;
                end
                else
                begin
                    dev_next     = head.entry.device_address;
                    regad_next   = head.entry.register_address;
                    data_next    = head.entry.write_data;
                    is_read_next = (head.entry.cls == i2cm_pkg::CL_READ);
                    byc_next     = 2'd0;
                    bc_next      = 4'd0;
                    shift_next   = 8'd0;
                    cnt_next     = '0;
                    ph_next      = i2cm_pkg::PH_PENDING;
                    status       = i2cm_pkg::ST_BUSY;
                end
            end
            i2cm_pkg::CL_TICK:
            begin
                if (ph_reg == i2cm_pkg::PH_PENDING)
                begin
                    tgt     = start_phase(scl_in, sda_in);
                    entered = 1'b1;
                end
                else if (busy && !hold)
                begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        entered = 1'b1;
                        case (ph_reg)
                            i2cm_pkg::PH_ST_CLK_LOW: tgt = i2cm_pkg::PH_ST_DATA_UP;
                            i2cm_pkg::PH_ST_DATA_UP, i2cm_pkg::PH_ST_RAISE:
                                tgt = i2cm_pkg::PH_ST_CLK_UP;
                            i2cm_pkg::PH_ST_CLK_UP, i2cm_pkg::PH_ST_SETTLE:
                                tgt = i2cm_pkg::PH_ST_DATA_DOWN;
                            i2cm_pkg::PH_ST_DATA_DOWN: tgt = i2cm_pkg::PH_ST_CLK_DOWN;
                            i2cm_pkg::PH_ST_CLK_DOWN:
                            begin
                                shift_next = dev_reg & 8'hFE;
                                case (byc_reg)
                                    2'd0: shift_next = dev_reg & 8'hFE;
                                    2'd1: shift_next = regad_reg;
                                    default: shift_next = is_read_reg ?
                                                          (dev_reg | 8'h01) : data_reg;
                                endcase
                                bc_next = 4'd0;
                                tgt     = i2cm_pkg::PH_WB_SET;
                            end
                            i2cm_pkg::PH_WB_SET: tgt = i2cm_pkg::PH_WB_HIGH;
                            i2cm_pkg::PH_WB_HIGH:
                                tgt = (bc_reg >= 4'd8 && sda_in) ?
                                      i2cm_pkg::PH_NACK_LOW : i2cm_pkg::PH_WB_LOW;
                            i2cm_pkg::PH_NACK_LOW: tgt = i2cm_pkg::PH_AB_LOW;
                            i2cm_pkg::PH_WB_LOW:
                            begin
                                if (bc_reg < 4'd8)
                                begin
                                    bc_next    = bc_reg + 4'd1;
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    tgt        = i2cm_pkg::PH_WB_SET;
                                end
                                else if (byc_reg >= 2'd2)
                                begin
                                    if (is_read_reg)
                                    begin
                                        shift_next = 8'd0;
                                        bc_next    = 4'd0;
                                        tgt        = i2cm_pkg::PH_RB_RELEASE;
                                    end
                                    else
                                    begin
                                        tgt = i2cm_pkg::PH_SP_LOW;
                                    end
                                end
                                else
                                begin
                                    byc_next = byc_reg + 2'd1;
                                    if (is_read_reg && byc_reg == 2'd1)
                                    begin
                                        // Repeated start before the read address.
                                        tgt = start_phase(scl_in, sda_in);
                                    end
                                    else
                                    begin
                                        // Next comes the register or the write data byte.
                                        shift_next = regad_reg;
                                        if (byc_reg == 2'd1)
                                        begin
                                            shift_next = data_reg;
                                        end
                                        bc_next = 4'd0;
                                        tgt     = i2cm_pkg::PH_WB_SET;
                                    end
                                end
                            end
                            i2cm_pkg::PH_RB_RELEASE: tgt = i2cm_pkg::PH_RB_HIGH;
                            i2cm_pkg::PH_RB_HIGH:
                            begin
                                shift_next = {shift_reg[6:0], sda_in};
                                tgt        = i2cm_pkg::PH_RB_LOW;
                            end
                            i2cm_pkg::PH_RB_LOW:
                            begin
                                bc_next = bc_reg + 4'd1;
                                tgt = (bc_reg + 4'd1 < 4'd8) ?
                                      i2cm_pkg::PH_RB_HIGH : i2cm_pkg::PH_SP_LOW;
                            end
                            i2cm_pkg::PH_SP_LOW:  tgt = i2cm_pkg::PH_SP_HIGH;
                            i2cm_pkg::PH_SP_HIGH: tgt = i2cm_pkg::PH_SP_END;
                            i2cm_pkg::PH_SP_END:
                            begin
                                entered = 1'b0;
                                ph_next = i2cm_pkg::PH_IDLE;
                                fin     = i2cm_pkg::ST_DONE_OK;
                            end
                            i2cm_pkg::PH_AB_LOW:  tgt = i2cm_pkg::PH_AB_HIGH;
                            i2cm_pkg::PH_AB_HIGH: tgt = i2cm_pkg::PH_AB_END;
                            i2cm_pkg::PH_AB_END:
                            begin
                                entered = 1'b0;
                                ph_next = i2cm_pkg::PH_IDLE;
                                fin     = i2cm_pkg::ST_NACK;
                            end
                            default:
                            begin
                                entered = 1'b0;
                                ph_next = i2cm_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (entered)
        begin
            ph_next  = tgt;
            cnt_next = load_val;
            case (tgt)
                i2cm_pkg::PH_ST_CLK_LOW: scl_next = 1'b0;
                i2cm_pkg::PH_ST_DATA_UP, i2cm_pkg::PH_RB_RELEASE:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                i2cm_pkg::PH_ST_RAISE, i2cm_pkg::PH_SP_END, i2cm_pkg::PH_AB_END:
                    sda_next = 1'b1;
                i2cm_pkg::PH_ST_CLK_UP:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                i2cm_pkg::PH_ST_DATA_DOWN:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end
                i2cm_pkg::PH_ST_CLK_DOWN, i2cm_pkg::PH_SP_LOW, i2cm_pkg::PH_AB_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                i2cm_pkg::PH_WB_SET:
                begin
                    scl_next = 1'b0;
                    sda_next = (bc_next < 4'd8) ? shift_next[7] : 1'b1;
                end
                i2cm_pkg::PH_WB_HIGH, i2cm_pkg::PH_RB_HIGH, i2cm_pkg::PH_SP_HIGH,
                i2cm_pkg::PH_AB_HIGH:
                    scl_next = 1'b1;
                i2cm_pkg::PH_WB_LOW, i2cm_pkg::PH_NACK_LOW, i2cm_pkg::PH_RB_LOW:
                    scl_next = 1'b0;
                default:
                begin
                end
            endcase
        end

        if (head.entry.cls == i2cm_pkg::CL_TICK && busy)
        begin
            if (fin != i2cm_pkg::ST_IDLE)
            begin
                status = fin;
            end
            else
            begin
                status = (ph_next != i2cm_pkg::PH_IDLE) ? i2cm_pkg::ST_BUSY :
                                                          i2cm_pkg::ST_IDLE;
            end
        end

        new_res.scl_drive = scl_next;
        new_res.sda_drive = sda_next;
        new_res.status    = status;
        new_res.read_data = (fin == i2cm_pkg::ST_DONE_OK && is_read_reg) ? shift_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= 16'd1;
            ph_reg          <= i2cm_pkg::PH_IDLE;
            cnt_reg         <= '0;
            shift_reg       <= 8'd0;
            bc_reg          <= 4'd0;
            byc_reg         <= 2'd0;
            is_read_reg     <= 1'b0;
            dev_reg         <= 8'd0;
            regad_reg       <= 8'd0;
            data_reg        <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            res_wr_reg      <= 1'b0;
            res_rd_reg      <= 1'b0;
            res_cnt_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                phase_ticks_reg <= cfg_data;
            end
            if (take)
            begin
                ph_reg      <= ph_next;
                cnt_reg     <= cnt_next;
                shift_reg   <= shift_next;
                bc_reg      <= bc_next;
                byc_reg     <= byc_next;
                is_read_reg <= is_read_next;
                dev_reg     <= dev_next;
                regad_reg   <= regad_next;
                data_reg    <= data_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                res_wr_reg  <= ~res_wr_reg;
            end
            if (do_pop)
            begin
                res_rd_reg <= ~res_rd_reg;
            end
            res_cnt_reg <= res_cnt_reg + {1'b0, take} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_mem_reg[res_wr_reg] <= new_res;
        end
    end

    assign empty  = (res_cnt_reg == 2'd0);
    assign result = res_mem_reg[res_rd_reg];

endmodule

FILE: rtl/i2c_master_register_access.sv
// I2C master for single register reads and writes, stepped by tick items.
// The input channel is a queue: an item is transferred when push is high and
// full is low. An item is a tick (carrying the sampled SCL and SDA levels), a
// register write command or a register read command. Every item yields exactly
// one result, which waits on the result ports while empty is low and is
// transferred when pop is high. A result carries the levels to drive on the
// two bus lines, a status code and, at the end of a good read, the byte read.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the number
// of ticks per bus phase; cfg_ready is always high, and writes belong between
// transfers while the block is idle.
// A result reaches the result ports through the input queue and then the
// result queue, both registered. One item is taken every cycle while an
// item is queued and the result queue has room: the engine updates its bus
// state machine once per taken item. Two-entry queues sit before and after
// the engine, so a stalled receiver first fills the result queue, then the
// input queue, and only then is full raised; nothing is dropped. Reset
// empties both queues, makes the engine idle and releases both lines.
module i2c_master_register_access
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  i2cm_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output i2cm_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    // The front sorts items by opcode and buffers them for the engine.
    i2cm_pkg::queue_head_t head;
    logic                  take;

    i2cm_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .head  (head),
        .take  (take)
    );

    // The engine runs the bus sequence and queues one result per item.
    i2cm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .head      (head),
        .take      (take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: dv/i2c_master_register_access_test.sv
`timescale 1ns / 100ps

module i2c_master_register_access_test;

    // Directed script rows: one item, or a run of ticks that carries the bus
    // engine back to idle with every byte acknowledged or with a NACK.
    typedef enum int {
        ROW_ITEM,
        ROW_RUN_ACK,
        ROW_RUN_NACK
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        i2cm_pkg::item_t   it;
        bit                typed;
        i2cm_pkg::result_t want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push;
    logic              full;
    i2cm_pkg::item_t   item;
    logic              empty;
    logic              pop;
    i2cm_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [15:0]       cfg_data;

    i2c_master_register_access i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // The run is bounded by a fixed time far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Shadow copy of the bus engine. It is stepped once per transferred item,
    // at the clock edge at which the block accepts that item into its input queue.
    logic [15:0]       ticks_cfg = 16'd1;
    i2cm_pkg::phase_t  ph = i2cm_pkg::PH_IDLE;
    logic [15:0]       cnt = '0;
    logic [7:0]        shreg = '0;
    logic [3:0]        bits = '0;
    logic [1:0]        bytes = '0;
    logic              rd_mode = 1'b0;
    logic [7:0]        dev = '0;
    logic [7:0]        regn = '0;
    logic [7:0]        wdat = '0;
    logic              scl_q = 1'b1;
    logic              sda_q = 1'b1;

    i2cm_pkg::result_t pending_bus_results[$];
    int                mismatches = 0;

    // Controls shared between the stimulus, the receiver and the sampling processes.
    int                send_idle_pct = 32;
    int                recv_idle_pct = 75;
    int                hold_left = 0;
    bit                typed_row = 1'b0;
    i2cm_pkg::result_t typed_want = '0;

    // A setting of zero behaves as one tick per phase.
    function automatic logic [15:0] bus_load();
        return (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg;
    endfunction

    function automatic bit raises_scl(i2cm_pkg::phase_t p);
        return p == i2cm_pkg::PH_ST_CLK_UP || p == i2cm_pkg::PH_WB_HIGH ||
               p == i2cm_pkg::PH_RB_HIGH || p == i2cm_pkg::PH_SP_HIGH ||
               p == i2cm_pkg::PH_AB_HIGH;
    endfunction

    // Entering a phase sets the driven line levels and reloads the counter.
    function automatic void bus_enter(i2cm_pkg::phase_t p);
        ph = p;
        cnt = bus_load();
        case (p)
            i2cm_pkg::PH_ST_CLK_LOW:   scl_q = 1'b0;
            i2cm_pkg::PH_ST_DATA_UP:
            begin
                scl_q = 1'b0;
                sda_q = 1'b1;
            end
            i2cm_pkg::PH_ST_RAISE:     sda_q = 1'b1;
            i2cm_pkg::PH_ST_CLK_UP:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
            end
            i2cm_pkg::PH_ST_DATA_DOWN:
            begin
                scl_q = 1'b1;
                sda_q = 1'b0;
            end
            i2cm_pkg::PH_ST_CLK_DOWN:
            begin
                scl_q = 1'b0;
                sda_q = 1'b0;
            end
            i2cm_pkg::PH_WB_SET:
            begin
                // Past the eighth bit the line is released for the slave's ack.
                scl_q = 1'b0;
                sda_q = (bits < 4'd8) ? shreg[7] : 1'b1;
            end
            i2cm_pkg::PH_WB_HIGH, i2cm_pkg::PH_RB_HIGH, i2cm_pkg::PH_SP_HIGH,
            i2cm_pkg::PH_AB_HIGH:
                scl_q = 1'b1;
            i2cm_pkg::PH_WB_LOW, i2cm_pkg::PH_NACK_LOW, i2cm_pkg::PH_RB_LOW:
                scl_q = 1'b0;
            i2cm_pkg::PH_RB_RELEASE:
            begin
                scl_q = 1'b0;
                sda_q = 1'b1;
            end
            i2cm_pkg::PH_SP_LOW, i2cm_pkg::PH_AB_LOW:
            begin
                scl_q = 1'b0;
                sda_q = 1'b0;
            end
            i2cm_pkg::PH_SP_END, i2cm_pkg::PH_AB_END: sda_q = 1'b1;
            default: ;
        endcase
    endfunction

    // The start condition picks its first phase from the sampled lines.
    function automatic void bus_start(logic scl, logic sda);
        if (scl)
            bus_enter(sda ? i2cm_pkg::PH_ST_SETTLE : i2cm_pkg::PH_ST_CLK_LOW);
        else
            bus_enter(i2cm_pkg::PH_ST_RAISE);
    endfunction

    function automatic void bus_load_byte();
        case (bytes)
            2'd0:    shreg = dev & 8'hFE;
            2'd1:    shreg = regn;
            default: shreg = rd_mode ? (dev | 8'h01) : wdat;
        endcase
        bits = '0;
        bus_enter(i2cm_pkg::PH_WB_SET);
    endfunction

    // Closes the current phase. ST_IDLE means the transfer goes on.
    function automatic i2cm_pkg::status_t bus_end_phase(logic scl, logic sda);
        case (ph)
            i2cm_pkg::PH_ST_CLK_LOW:
                bus_enter(i2cm_pkg::PH_ST_DATA_UP);
            i2cm_pkg::PH_ST_DATA_UP, i2cm_pkg::PH_ST_RAISE:
                bus_enter(i2cm_pkg::PH_ST_CLK_UP);
            i2cm_pkg::PH_ST_CLK_UP, i2cm_pkg::PH_ST_SETTLE:
                bus_enter(i2cm_pkg::PH_ST_DATA_DOWN);
            i2cm_pkg::PH_ST_DATA_DOWN:
                bus_enter(i2cm_pkg::PH_ST_CLK_DOWN);
            i2cm_pkg::PH_ST_CLK_DOWN:
                bus_load_byte();
            i2cm_pkg::PH_WB_SET:
                bus_enter(i2cm_pkg::PH_WB_HIGH);
            i2cm_pkg::PH_WB_HIGH:
                bus_enter((bits >= 4'd8 && sda) ? i2cm_pkg::PH_NACK_LOW :
                                                  i2cm_pkg::PH_WB_LOW);
            i2cm_pkg::PH_NACK_LOW:
                bus_enter(i2cm_pkg::PH_AB_LOW);
            i2cm_pkg::PH_WB_LOW:
            begin
                if (bits < 4'd8)
                begin
                    bits = bits + 4'd1;
                    shreg = {shreg[6:0], 1'b0};
                    bus_enter(i2cm_pkg::PH_WB_SET);
                end
                else if (bytes >= 2'd2)
                begin
                    if (rd_mode)
                    begin
                        shreg = '0;
                        bits = '0;
                        bus_enter(i2cm_pkg::PH_RB_RELEASE);
                    end
                    else
                    begin
                        bus_enter(i2cm_pkg::PH_SP_LOW);
                    end
                end
                else
                begin
                    bytes = bytes + 2'd1;
                    // A read turns the bus around with a repeated start.
                    if (rd_mode && bytes == 2'd2)
                        bus_start(scl, sda);
                    else
                        bus_load_byte();
                end
            end
            i2cm_pkg::PH_RB_RELEASE:
                bus_enter(i2cm_pkg::PH_RB_HIGH);
            i2cm_pkg::PH_RB_HIGH:
            begin
                shreg = {shreg[6:0], sda};
                bus_enter(i2cm_pkg::PH_RB_LOW);
            end
            i2cm_pkg::PH_RB_LOW:
            begin
                bits = bits + 4'd1;
                bus_enter((bits < 4'd8) ? i2cm_pkg::PH_RB_HIGH : i2cm_pkg::PH_SP_LOW);
            end
            i2cm_pkg::PH_SP_LOW:
                bus_enter(i2cm_pkg::PH_SP_HIGH);
            i2cm_pkg::PH_SP_HIGH:
                bus_enter(i2cm_pkg::PH_SP_END);
            i2cm_pkg::PH_SP_END:
            begin
                ph = i2cm_pkg::PH_IDLE;
                return i2cm_pkg::ST_DONE_OK;
            end
            i2cm_pkg::PH_AB_LOW:
                bus_enter(i2cm_pkg::PH_AB_HIGH);
            i2cm_pkg::PH_AB_HIGH:
                bus_enter(i2cm_pkg::PH_AB_END);
            i2cm_pkg::PH_AB_END:
            begin
                ph = i2cm_pkg::PH_IDLE;
                return i2cm_pkg::ST_NACK;
            end
            default:
                ph = i2cm_pkg::PH_IDLE;
        endcase
        return i2cm_pkg::ST_IDLE;
    endfunction

    // One item in, the result it should produce out.
    function automatic i2cm_pkg::result_t bus_step(i2cm_pkg::item_t it);
        i2cm_pkg::result_t r;
        i2cm_pkg::status_t st;
        i2cm_pkg::status_t fin;
        logic              busy;
        r = '0;
        fin = i2cm_pkg::ST_IDLE;
        busy = (ph != i2cm_pkg::PH_IDLE);
        if (it.opcode == i2cm_pkg::OP_WRITE || it.opcode == i2cm_pkg::OP_READ)
        begin
            if (busy)
            begin
                st = i2cm_pkg::ST_REJECT;
            end
            else
            begin
                dev = it.device_address;
                regn = it.register_address;
                wdat = it.write_data;
                rd_mode = (it.opcode == i2cm_pkg::OP_READ);
                bytes = '0;
                bits = '0;
                shreg = '0;
                cnt = '0;
                ph = i2cm_pkg::PH_PENDING;
                st = i2cm_pkg::ST_BUSY;
            end
        end
        else if (it.opcode == i2cm_pkg::OP_NONE || !busy)
        begin
            st = busy ? i2cm_pkg::ST_BUSY : i2cm_pkg::ST_IDLE;
        end
        else if (ph == i2cm_pkg::PH_PENDING)
        begin
            bus_start(it.scl_sampled, it.sda_sampled);
            st = i2cm_pkg::ST_BUSY;
        end
        else
        begin
            // A phase that raises SCL waits while the slave holds it low.
            if (!(raises_scl(ph) && !it.scl_sampled))
            begin
                if (cnt > 16'd0)
                    cnt = cnt - 16'd1;
                if (cnt == 16'd0)
                    fin = bus_end_phase(it.scl_sampled, it.sda_sampled);
            end
            if (fin != i2cm_pkg::ST_IDLE)
            begin
                st = fin;
                if (fin == i2cm_pkg::ST_DONE_OK && rd_mode)
                    r.read_data = shreg;
            end
            else
            begin
                st = (ph != i2cm_pkg::PH_IDLE) ? i2cm_pkg::ST_BUSY : i2cm_pkg::ST_IDLE;
            end
        end
        r.scl_drive = scl_q;
        r.sda_drive = sda_q;
        r.status = st;
        return r;
    endfunction

    function automatic bit ack_slot();
        return ph == i2cm_pkg::PH_WB_HIGH && bits >= 4'd8;
    endfunction

    // A tick that always lets the clock rise. The data line is pulled low only
    // in the ack slot, so reads return all ones unless a NACK is wanted.
    function automatic i2cm_pkg::item_t run_tick(bit nack);
        i2cm_pkg::item_t it;
        it = '0;
        it.opcode = i2cm_pkg::OP_TICK;
        it.scl_sampled = 1'b1;
        it.sda_sampled = nack | !ack_slot();
        return it;
    endfunction

    // Random items are mostly well-formed transfers: a command on an idle
    // engine, then ticks that mostly acknowledge, with some clock stretching,
    // some rejected commands and some unused opcodes as noise.
    function automatic i2cm_pkg::item_t pick_item();
        i2cm_pkg::item_t it;
        int              r;
        it.device_address = 8'($urandom_range(0, 255));
        it.register_address = 8'($urandom_range(0, 255));
        it.write_data = 8'($urandom_range(0, 255));
        it.scl_sampled = ($urandom_range(0, 99) < 88);
        it.sda_sampled = ack_slot() ? ($urandom_range(0, 99) < 8) :
                                      1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (ph == i2cm_pkg::PH_IDLE)
        begin
            if (r < 75)
                it.opcode = (r < 37) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
            else if (r < 90)
                it.opcode = i2cm_pkg::OP_TICK;
            else
                it.opcode = i2cm_pkg::OP_NONE;
        end
        else
        begin
            if (r < 93)
                it.opcode = i2cm_pkg::OP_TICK;
            else if (r < 97)
                it.opcode = (r < 95) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
            else
                it.opcode = i2cm_pkg::OP_NONE;
        end
        return it;
    endfunction

    // Everything is sampled at the rising edge, before the block's registers
    // update, while every input was set up at the preceding falling edge.
    always @(posedge clk)
    begin : sample
        i2cm_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                ticks_cfg = cfg_data;
            if (push && !full)
            begin
                want = bus_step(item);
                if (typed_row)
                    want = typed_want;
                pending_bus_results.push_back(want);
            end
            if (pop && !empty)
            begin
                if (pending_bus_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = pending_bus_results.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: result mismatch, expected %h, got %h",
                                 $time, want, result);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Receiver: pops at random, except during a long hold-off that lets the
    // block back up until it stalls the sender.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offers one item and returns at the falling edge after its transfer.
    // Push stays high so that back-to-back items need no second assignment.
    task automatic offer(input i2cm_pkg::item_t it, input bit typed,
                         input i2cm_pkg::result_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        typed_row = typed;
        typed_want = want;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Runs the bus engine back to idle and waits until every result is in,
    // so that the next configuration write finds the block idle.
    task automatic settle_engine();
        while (ph != i2cm_pkg::PH_IDLE)
            offer(run_tick(1'b0), 1'b0, '0);
        push <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_ticks(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic row_t mk_row(row_kind_t k, i2cm_pkg::opcode_t op, logic [7:0] d,
                                    logic [7:0] ra, logic [7:0] wd, logic scl,
                                    logic sda, bit typed, logic ws, logic wsd,
                                    i2cm_pkg::status_t wst);
        row_t row;
        row.kind = k;
        row.it.opcode = op;
        row.it.device_address = d;
        row.it.register_address = ra;
        row.it.write_data = wd;
        row.it.scl_sampled = scl;
        row.it.sda_sampled = sda;
        row.typed = typed;
        row.want.scl_drive = ws;
        row.want.sda_drive = wsd;
        row.want.status = wst;
        row.want.read_data = 8'h00;
        return row;
    endfunction

    // Random phases: ticks per phase, sender and receiver idle rates, items.
    // The last one uses the largest setting and ends with a transfer in flight.
    logic [15:0] phase_setting[5] = '{16'd1, 16'd0, 16'd3, 16'd2, 16'hFFFF};
    int          phase_send_idle[5] = '{32, 75, 0, 0, 0};
    int          phase_recv_idle[5] = '{75, 32, 0, 0, 0};
    int          phase_items[5] = '{140, 110, 100, 70, 30};

    initial
    begin : stimulus
        row_t            script[$];
        i2cm_pkg::item_t it;
        int              counted;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset setting of one tick per phase.
        // An idle engine reports idle with both lines released, whatever it
        // samples, and ignores the unused opcode.
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_IDLE));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_IDLE));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_NONE, 8'hFF, 8'hFF, 8'hFF,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_IDLE));
        // A write is taken; further commands while busy are rejected.
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_WRITE, 8'hFF, 8'h00, 8'hFF,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_WRITE, 8'h12, 8'h34, 8'h56,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_REJECT));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_READ, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_REJECT));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_NONE, 8'h00, 8'h00, 8'h00,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        // Start with both lines high: hold, SDA down, SCL down, first bit.
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b0, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b1, 1'b1, 1'b0, 1'b0, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b1, 1'b1, 1'b0, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_RUN_ACK, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b0, 1'b0, 1'b0, 1'b0, i2cm_pkg::ST_IDLE));
        // After a finish both lines stay released.
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_IDLE));
        // Read with SDA sampled low while SCL is high: SCL goes down first.
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_READ, 8'h00, 8'hFF, 8'h00,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b0, 1'b1, 1'b0, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b0, 1'b1, 1'b0, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_RUN_ACK, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b0, 1'b0, 1'b0, 1'b0, i2cm_pkg::ST_IDLE));
        // Read with SCL sampled low: release SDA, then a stretched SCL rise.
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_READ, 8'h55, 8'hAA, 8'hFF,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b0, 1'b1, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b0, 1'b0, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        // The slave never acknowledges, so the transfer aborts.
        script.push_back(mk_row(ROW_RUN_NACK, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b1, 1'b0, 1'b0, 1'b0, i2cm_pkg::ST_IDLE));
        script.push_back(mk_row(ROW_ITEM, i2cm_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h00,
                                1'b1, 1'b1, 1'b1, 1'b1, 1'b1, i2cm_pkg::ST_BUSY));
        script.push_back(mk_row(ROW_RUN_ACK, i2cm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00,
                                1'b1, 1'b0, 1'b0, 1'b0, 1'b0, i2cm_pkg::ST_IDLE));

        foreach (script[i])
        begin
            if (script[i].kind == ROW_ITEM)
                offer(script[i].it, script[i].typed, script[i].want);
            else
                while (ph != i2cm_pkg::PH_IDLE)
                    offer(run_tick(script[i].kind == ROW_RUN_NACK), 1'b0, '0);
        end
        settle_engine();

        // Random part, one phase per setting.
        for (int k = 0; k < 5; k++)
        begin
            write_ticks(phase_setting[k]);
            send_idle_pct = phase_send_idle[k];
            recv_idle_pct = phase_recv_idle[k];
            // Once, with no idling on either side, the receiver stops for a
            // long stretch while items keep coming.
            if (k == 2)
                hold_left = 120;
            counted = 0;
            while (counted < phase_items[k])
            begin
                it = pick_item();
                if (!(it.opcode == i2cm_pkg::OP_NONE ||
                      (it.opcode == i2cm_pkg::OP_TICK && ph == i2cm_pkg::PH_IDLE)))
                    counted++;
                offer(it, 1'b0, '0);
            end
            if (k < 4)
                settle_engine();
        end

        push <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending_bus_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
